// ===== sv/gcab_pkg.sv =====
`timescale 1ns / 1ps

package gcab_pkg;

    // field widths
    localparam int unsigned DIM_W      = 11;
    localparam int unsigned POS_W      = 13;
    localparam int unsigned OFS_W      = 12;
    localparam int unsigned SUM_POS_W  = 14;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned PIX_W      = 32;
    localparam int unsigned ADDR_W     = 22;
    localparam int unsigned PROD_W     = 16;
    localparam int unsigned ACC_W      = 17;
    localparam int unsigned IN_DATA_W  = 128;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned CFG_IDX_W  = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME_HEIGHT = 8'd1;

    // reset values and limits
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd1920;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd1080;
    localparam int unsigned MAX_FRAME_DIM_DEF = 1920;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [ACC_W-1:0]  ROUND_BIAS = 17'd127;

    // valid bits of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_valid_t;

    // advance enables of the four pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // floor(x / 255) for x below 65280, by reciprocal with correction
    function automatic logic [CHAN_W-1:0] div255(input logic [ACC_W-1:0] x);
        logic [ACC_W:0] t;
        begin
            t = {1'b0, x} + {9'd0, x[ACC_W-1:8]} + 18'd1;
            div255 = t[15:8];
        end
    endfunction

endpackage

// ===== sv/gcab_cfg.sv =====
`timescale 1ns / 1ps

module gcab_cfg #(
    parameter int unsigned MAX_FRAME_DIM = gcab_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gcab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcab_pkg::DIM_W-1:0]      cfg_data,
    output logic [gcab_pkg::DIM_W-1:0]      frame_width,
    output logic [gcab_pkg::DIM_W-1:0]      frame_height,
    output logic                            size_ok
);

    localparam logic [gcab_pkg::POS_W-1:0] MaxDim = gcab_pkg::POS_W'(MAX_FRAME_DIM);

    logic [gcab_pkg::DIM_W-1:0] width_reg;
    logic [gcab_pkg::DIM_W-1:0] height_reg;

    assign cfg_ready    = 1'b1;
    assign frame_width  = width_reg;
    assign frame_height = height_reg;

    // frame size is usable when both dimensions are nonzero and within the limit
    always_comb
    begin
        size_ok = (width_reg != '0) && (height_reg != '0) &&
                  ({2'b00, width_reg} <= MaxDim) && ({2'b00, height_reg} <= MaxDim);
    end

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gcab_pkg::FRAME_WIDTH_RST;
            height_reg <= gcab_pkg::FRAME_HEIGHT_RST;
        end
        else
        begin
            if (cfg_valid && cfg_index == gcab_pkg::CFG_IDX_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == gcab_pkg::CFG_IDX_FRAME_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

endmodule

// ===== sv/gcab_datapath.sv =====
`timescale 1ns / 1ps

module gcab_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [gcab_pkg::DIM_W-1:0]     frame_width,
    input  logic [gcab_pkg::DIM_W-1:0]     frame_height,
    input  logic                           size_ok,
    input  logic                           in_valid,
    input  logic [gcab_pkg::POS_W-1:0]     image_left,
    input  logic [gcab_pkg::POS_W-1:0]     image_top,
    input  logic [gcab_pkg::OFS_W-1:0]     sample_col,
    input  logic [gcab_pkg::OFS_W-1:0]     sample_row,
    input  logic [gcab_pkg::CHAN_W-1:0]    coverage,
    input  logic [gcab_pkg::PIX_W-1:0]     text_color,
    input  logic [gcab_pkg::PIX_W-1:0]     old_pixel,
    input  gcab_pkg::stage_en_t            en,
    output gcab_pkg::stage_valid_t         vld,
    output logic [gcab_pkg::ADDR_W-1:0]    pixel_address,
    output logic [gcab_pkg::PIX_W-1:0]     new_pixel
);

    localparam int unsigned CW = gcab_pkg::CHAN_W;
    localparam int unsigned AW = gcab_pkg::ACC_W;

    // stage 1: frame position and coverage times opacity
    logic                                s1_vld_reg;
    logic [gcab_pkg::SUM_POS_W-1:0]      s1_col_reg;
    logic [gcab_pkg::SUM_POS_W-1:0]      s1_row_reg;
    logic [gcab_pkg::PROD_W-1:0]         s1_prod_reg;
    logic [3*CW-1:0]                     s1_rgb_reg;
    logic [gcab_pkg::PIX_W-1:0]          s1_old_reg;
    logic [gcab_pkg::SUM_POS_W-1:0]      s1_col_next;
    logic [gcab_pkg::SUM_POS_W-1:0]      s1_row_next;
    logic [gcab_pkg::PROD_W-1:0]         s1_prod_next;

    // stage 2: clipping, source alpha, row offset
    logic                                s2_vld_reg;
    logic [CW-1:0]                       s2_alpha_reg;
    logic [gcab_pkg::ADDR_W-1:0]         s2_rowofs_reg;
    logic [gcab_pkg::DIM_W-1:0]          s2_col_reg;
    logic [3*CW-1:0]                     s2_rgb_reg;
    logic [gcab_pkg::PIX_W-1:0]          s2_old_reg;
    logic                                s2_in_frame;

    // stage 3: weighted channel sums and address
    logic                                s3_vld_reg;
    logic [AW-1:0]                       s3_r_reg;
    logic [AW-1:0]                       s3_g_reg;
    logic [AW-1:0]                       s3_b_reg;
    logic [AW-1:0]                       s3_a_reg;
    logic [CW-1:0]                       s3_alpha_reg;
    logic [gcab_pkg::ADDR_W-1:0]         s3_addr_reg;
    logic [CW-1:0]                       s2_inv;

    // stage 4: rounded quotients, result register
    logic                                s4_vld_reg;
    logic [gcab_pkg::ADDR_W-1:0]         s4_addr_reg;
    logic [gcab_pkg::PIX_W-1:0]          s4_pixel_reg;
    logic [CW-1:0]                       s4_alpha_next;

    assign vld.s1 = s1_vld_reg;
    assign vld.s2 = s2_vld_reg;
    assign vld.s3 = s3_vld_reg;
    assign vld.s4 = s4_vld_reg;
    assign pixel_address = s4_addr_reg;
    assign new_pixel     = s4_pixel_reg;

    // stage 1 arithmetic
    always_comb
    begin
        s1_col_next  = {image_left[gcab_pkg::POS_W-1], image_left} +
                       {2'b00, sample_col};
        s1_row_next  = {image_top[gcab_pkg::POS_W-1], image_top} +
                       {2'b00, sample_row};
        s1_prod_next = coverage * (gcab_pkg::FULL_SCALE - text_color[CW-1:0]);
    end

    // stage 2 clip test, column and row both nonnegative and below the frame size
    always_comb
    begin
        s2_in_frame = !s1_col_reg[gcab_pkg::SUM_POS_W-1] &&
                      !s1_row_reg[gcab_pkg::SUM_POS_W-1] &&
                      (s1_col_reg[gcab_pkg::SUM_POS_W-2:0] < {2'b00, frame_width}) &&
                      (s1_row_reg[gcab_pkg::SUM_POS_W-2:0] < {2'b00, frame_height});
        s2_inv = gcab_pkg::FULL_SCALE - s2_alpha_reg;
    end

    // stage 4 alpha, wraps to eight bits
    always_comb
    begin
        s4_alpha_next = CW'(s3_alpha_reg + gcab_pkg::div255(s3_a_reg));
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                s1_vld_reg <= in_valid && size_ok;
            end
            if (en.s2)
            begin
                s2_vld_reg <= s1_vld_reg && s2_in_frame;
            end
            if (en.s3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en.s4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_col_reg  <= s1_col_next;
            s1_row_reg  <= s1_row_next;
            s1_prod_reg <= s1_prod_next;
            s1_rgb_reg  <= text_color[gcab_pkg::PIX_W-1:CW];
            s1_old_reg  <= old_pixel;
        end
        if (en.s2)
        begin
            s2_alpha_reg  <= gcab_pkg::div255({1'b0, s1_prod_reg});
            s2_rowofs_reg <= s1_row_reg[gcab_pkg::DIM_W-1:0] * frame_width;
            s2_col_reg    <= s1_col_reg[gcab_pkg::DIM_W-1:0];
            s2_rgb_reg    <= s1_rgb_reg;
            s2_old_reg    <= s1_old_reg;
        end
        if (en.s3)
        begin
            s3_r_reg <= AW'(s2_rgb_reg[3*CW-1:2*CW] * s2_alpha_reg) +
                        AW'(s2_old_reg[CW-1:0] * s2_inv) + gcab_pkg::ROUND_BIAS;
            s3_g_reg <= AW'(s2_rgb_reg[2*CW-1:CW] * s2_alpha_reg) +
                        AW'(s2_old_reg[2*CW-1:CW] * s2_inv) + gcab_pkg::ROUND_BIAS;
            s3_b_reg <= AW'(s2_rgb_reg[CW-1:0] * s2_alpha_reg) +
                        AW'(s2_old_reg[3*CW-1:2*CW] * s2_inv) + gcab_pkg::ROUND_BIAS;
            s3_a_reg <= AW'(s2_old_reg[4*CW-1:3*CW] * s2_inv) + gcab_pkg::ROUND_BIAS;
            s3_alpha_reg <= s2_alpha_reg;
            s3_addr_reg  <= s2_rowofs_reg + {11'd0, s2_col_reg};
        end
        if (en.s4)
        begin
            s4_addr_reg  <= s3_addr_reg;
            s4_pixel_reg <= {s4_alpha_next,
                             gcab_pkg::div255(s3_b_reg),
                             gcab_pkg::div255(s3_g_reg),
                             gcab_pkg::div255(s3_r_reg)};
        end
    end

endmodule

// ===== sv/glyph_coverage_alpha_blend_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata, one coverage sample
// m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata, address and pixel
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// four register stages: position and coverage product, clip and alpha and
// row multiply, channel sums and address add, divide by 255 into the output register.
// one sample per cycle while the output is not stalled; out-of-frame samples vanish.
// each stage moves when it is empty or the next one moves, so bubbles close up under stall.
// reset clears all valid bits and loads width 1920, height 1080; cfg_ready is always high.

module glyph_coverage_alpha_blend_unit #(
    parameter int unsigned MAX_FRAME_DIM = gcab_pkg::MAX_FRAME_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // image_left[12:0], image_top[25:13], sample_col[37:26], sample_row[49:38],
    // coverage[57:50], text_color[89:58], old_pixel[121:90], zero pad[127:122]
    input  logic [gcab_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_address[21:0], new_pixel[53:22], zero pad[55:54]
    output logic [gcab_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcab_pkg::DIM_W-1:0]        cfg_data
);

    logic [gcab_pkg::DIM_W-1:0]  frame_width;
    logic [gcab_pkg::DIM_W-1:0]  frame_height;
    logic                        size_ok;
    gcab_pkg::stage_en_t         en;
    gcab_pkg::stage_valid_t      vld;
    logic [gcab_pkg::ADDR_W-1:0] pixel_address;
    logic [gcab_pkg::PIX_W-1:0]  new_pixel;

    gcab_cfg #(
        .MAX_FRAME_DIM (MAX_FRAME_DIM)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .size_ok      (size_ok)
    );

    // stage advance chain from the output back to the input
    always_comb
    begin
        en.s4 = !vld.s4 || m_axis_tready;
        en.s3 = !vld.s3 || en.s4;
        en.s2 = !vld.s2 || en.s3;
        en.s1 = !vld.s1 || en.s2;
    end

    assign s_axis_tready = en.s1;

    gcab_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_width   (frame_width),
        .frame_height  (frame_height),
        .size_ok       (size_ok),
        .in_valid      (s_axis_tvalid),
        .image_left    (s_axis_tdata[12:0]),
        .image_top     (s_axis_tdata[25:13]),
        .sample_col    (s_axis_tdata[37:26]),
        .sample_row    (s_axis_tdata[49:38]),
        .coverage      (s_axis_tdata[57:50]),
        .text_color    (s_axis_tdata[89:58]),
        .old_pixel     (s_axis_tdata[121:90]),
        .en            (en),
        .vld           (vld),
        .pixel_address (pixel_address),
        .new_pixel     (new_pixel)
    );

    // result transaction
    assign m_axis_tvalid = vld.s4;
    assign m_axis_tdata  = {2'b00, new_pixel, pixel_address};

endmodule

// ===== sv/gcab_checker.sv =====
`timescale 1ns / 1ps

module gcab_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tready,
    input logic [gcab_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // an open output path never blocks the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // address stays inside the largest frame that 11-bit sizes allow
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:0] < 22'd4190209)
        else $error("pixel address out of range");

endmodule

bind glyph_coverage_alpha_blend_unit gcab_checker u_gcab_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
